FILE: hw/rtl/lase_pkg.sv
package lase_pkg;

	localparam int CAPACITY = 16;
	localparam int VALUE_W  = 32;
	localparam int SLOT_W   = $clog2(CAPACITY);
	localparam int LINK_W   = $clog2(CAPACITY + 1);
	localparam int COUNT_W  = 5;
	localparam logic [LINK_W-1:0] NIL_LINK = LINK_W'(CAPACITY);

	typedef enum logic [1:0] {
		OP_ADD    = 2'd0,
		OP_REMOVE = 2'd1,
		OP_SEARCH = 2'd2,
		OP_CLEAR  = 2'd3
	} op_t;

	typedef enum logic [1:0] {
		STAT_DONE      = 2'd0,
		STAT_PRESENT   = 2'd1,
		STAT_NOT_FOUND = 2'd2,
		STAT_FULL      = 2'd3
	} status_t;

	typedef enum logic [1:0] {
		S_IDLE,
		S_WALK,
		S_FINISH
	} state_t;

	typedef struct packed {
		logic    load;
		logic    step;
		logic    add_commit;
		logic    rem_commit;
		logic    clear;
		logic    resp_load;
		status_t resp_status;
	} cmd_t;

	typedef struct packed {
		logic hit;
		logic walk_end;
		logic full;
		op_t  op;
	} sts_t;

endpackage

FILE: hw/rtl/lase_ctrl.sv
module lase_ctrl (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                in_valid,
	input  logic [1:0]          in_op,
	output logic                in_ready,
	output logic                out_valid,
	input  logic                out_ready,
	input  lase_pkg::sts_t      sts,
	output lase_pkg::cmd_t      cmd
);

	lase_pkg::state_t state_q, state_d;
	logic             out_valid_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= lase_pkg::S_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cmd.resp_load)
				out_valid_q <= 1'b1;
			else if (out_ready)
				out_valid_q <= 1'b0;
		end
	end

	assign out_valid = out_valid_q;

	always_comb begin
		state_d         = state_q;
		cmd             = '0;
		cmd.resp_status = lase_pkg::STAT_DONE;
		in_ready        = 1'b0;
		unique case (state_q)
			lase_pkg::S_IDLE: begin
				in_ready = 1'b1;
				if (in_valid) begin
					cmd.load = 1'b1;
					state_d  = (lase_pkg::op_t'(in_op) == lase_pkg::OP_CLEAR) ?
						lase_pkg::S_FINISH : lase_pkg::S_WALK;
				end
			end
			lase_pkg::S_WALK: begin
				if (sts.hit || sts.walk_end)
					state_d = lase_pkg::S_FINISH;
				else
					cmd.step = 1'b1;
			end
			lase_pkg::S_FINISH: begin
				// hold the result until the output register is free
				if (!out_valid_q || out_ready) begin
					cmd.resp_load = 1'b1;
					state_d       = lase_pkg::S_IDLE;
					unique case (sts.op)
						lase_pkg::OP_ADD: begin
							if (sts.hit)
								cmd.resp_status = lase_pkg::STAT_PRESENT;
							else if (sts.full)
								cmd.resp_status = lase_pkg::STAT_FULL;
							else
								cmd.add_commit = 1'b1;
						end
						lase_pkg::OP_REMOVE: begin
							if (sts.hit)
								cmd.rem_commit = 1'b1;
							else
								cmd.resp_status = lase_pkg::STAT_NOT_FOUND;
						end
						lase_pkg::OP_SEARCH: begin
							if (!sts.hit)
								cmd.resp_status = lase_pkg::STAT_NOT_FOUND;
						end
						lase_pkg::OP_CLEAR: begin
							cmd.clear = 1'b1;
						end
						default: begin
							cmd.resp_status = lase_pkg::STAT_DONE;
						end
					endcase
				end
			end
			default: begin
				state_d = lase_pkg::S_IDLE;
			end
		endcase
	end

endmodule

FILE: hw/rtl/lase_dp.sv
module lase_dp (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic [1:0]                   in_op,
	input  logic [lase_pkg::VALUE_W-1:0] in_value,
	input  lase_pkg::cmd_t               cmd,
	output lase_pkg::sts_t               sts,
	output logic [7:0]                   out_data
);

	logic [lase_pkg::VALUE_W-1:0] value_q [lase_pkg::CAPACITY];
	logic [lase_pkg::LINK_W-1:0]  link_q  [lase_pkg::CAPACITY];

	logic [lase_pkg::LINK_W-1:0]  head_q, tail_q, free_q;
	logic [lase_pkg::LINK_W-1:0]  cur_q, prev_q, steps_q;
	logic [lase_pkg::COUNT_W-1:0] count_q, count_d;
	lase_pkg::op_t                op_q;
	logic [lase_pkg::VALUE_W-1:0] val_q;
	logic [7:0]                   resp_q;

	logic [lase_pkg::LINK_W-1:0]  rd_addr, link_rd;
	logic [lase_pkg::VALUE_W-1:0] cur_val;
	logic                         cur_vld, prev_vld, tail_vld;

	always_comb begin
		rd_addr  = cmd.add_commit ? free_q : cur_q;
		link_rd  = link_q[rd_addr[lase_pkg::SLOT_W-1:0]];
		cur_val  = value_q[cur_q[lase_pkg::SLOT_W-1:0]];
		cur_vld  = cur_q < lase_pkg::NIL_LINK;
		prev_vld = prev_q < lase_pkg::NIL_LINK;
		tail_vld = tail_q < lase_pkg::NIL_LINK;

		sts.walk_end = !cur_vld || (steps_q == lase_pkg::NIL_LINK);
		sts.hit      = !sts.walk_end && (cur_val == val_q);
		sts.full     = free_q >= lase_pkg::NIL_LINK;
		sts.op       = op_q;

		count_d = count_q;
		if (cmd.clear)
			count_d = '0;
		else if (cmd.add_commit)
			count_d = count_q + 1'b1;
		else if (cmd.rem_commit && count_q != '0)
			count_d = count_q - 1'b1;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < lase_pkg::CAPACITY; i++)
				link_q[i] <= lase_pkg::LINK_W'(i + 1);
			head_q  <= lase_pkg::NIL_LINK;
			tail_q  <= lase_pkg::NIL_LINK;
			free_q  <= '0;
			count_q <= '0;
		end else begin
			count_q <= count_d;
			if (cmd.clear) begin
				for (int i = 0; i < lase_pkg::CAPACITY; i++)
					link_q[i] <= lase_pkg::LINK_W'(i + 1);
				head_q <= lase_pkg::NIL_LINK;
				tail_q <= lase_pkg::NIL_LINK;
				free_q <= '0;
			end else if (cmd.add_commit) begin
				// append the free-chain head at the tail
				free_q <= link_rd;
				link_q[free_q[lase_pkg::SLOT_W-1:0]] <= lase_pkg::NIL_LINK;
				if (tail_vld)
					link_q[tail_q[lase_pkg::SLOT_W-1:0]] <= free_q;
				else
					head_q <= free_q;
				tail_q <= free_q;
			end else if (cmd.rem_commit) begin
				// a removed tail leaves its predecessor as the new tail
				if (cur_q == head_q)
					head_q <= link_rd;
				else if (prev_vld)
					link_q[prev_q[lase_pkg::SLOT_W-1:0]] <=
						(cur_q == tail_q) ? lase_pkg::NIL_LINK : link_rd;
				if (cur_q == tail_q)
					tail_q <= prev_q;
				// push the slot onto the front of the free chain
				link_q[cur_q[lase_pkg::SLOT_W-1:0]] <= free_q;
				free_q <= cur_q;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.add_commit)
			value_q[free_q[lase_pkg::SLOT_W-1:0]] <= val_q;
	end

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			op_q    <= lase_pkg::op_t'(in_op);
			val_q   <= in_value;
			cur_q   <= head_q;
			prev_q  <= lase_pkg::NIL_LINK;
			steps_q <= '0;
		end else if (cmd.step) begin
			prev_q  <= cur_q;
			cur_q   <= link_rd;
			steps_q <= steps_q + 1'b1;
		end
		if (cmd.resp_load)
			resp_q <= {(count_d == '0), count_d, cmd.resp_status};
	end

	assign out_data = resp_q;

endmodule

FILE: hw/rtl/linked_array_set_engine_unit.sv
// Set of up to 16 distinct 32-bit values kept as a linked chain in a slot
// store. One input beat carries an op (add, remove, search, clear) and a value;
// one output beat returns status, element count and an empty flag. Items are
// handled one at a time: a clear goes straight from acceptance to the finish
// state, the other ops first walk the chain, stepping past at most 16 slots; the
// next beat is accepted in the cycle after the result is loaded. The walk reads
// one slot of the value and link stores each cycle. A finished result waits in
// the output register while the next beat is accepted; if it is still held when
// the next op finishes, that op stalls until the result beat leaves.
module linked_array_set_engine_unit (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_axis_tvalid,
	output logic        s_axis_tready,
	input  logic [31:0] s_axis_tdata,   // elem_value[31:0]
	input  logic [1:0]  s_axis_tuser,   // op[1:0]
	output logic        m_axis_tvalid,
	input  logic        m_axis_tready,
	output logic [7:0]  m_axis_tdata    // status[1:0], count[6:2], is_empty[7]
);

	lase_pkg::cmd_t cmd;
	lase_pkg::sts_t sts;

	lase_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (s_axis_tvalid),
		.in_op     (s_axis_tuser),
		.in_ready  (s_axis_tready),
		.out_valid (m_axis_tvalid),
		.out_ready (m_axis_tready),
		.sts       (sts),
		.cmd       (cmd)
	);

	lase_dp u_dp (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_op    (s_axis_tuser),
		.in_value (s_axis_tdata),
		.cmd      (cmd),
		.sts      (sts),
		.out_data (m_axis_tdata)
	);

endmodule

FILE: tb/linked_array_set_engine_unit_tb.sv
module linked_array_set_engine_unit_tb;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int RANDOM_ITEMS = 1420;
	localparam int POOL_SIZE    = 24;
	localparam int DRAIN_CYCLES = 40;
	localparam int CYCLE_LIMIT  = 600000;

	typedef struct packed {
		lase_pkg::status_t status;
		logic [4:0]        count;
		logic              is_empty;
	} set_reply_t;

	typedef struct packed {
		lase_pkg::op_t op;
		logic [31:0]   value;
		logic          known;
		set_reply_t    reply;
	} dir_row_t;

	localparam int DIR_ROWS = 28;
	localparam dir_row_t DIR_TABLE [DIR_ROWS] = '{
		'{lase_pkg::OP_SEARCH, 32'h0000_0000, 1'b1, '{lase_pkg::STAT_NOT_FOUND, 5'd0, 1'b1}},
		'{lase_pkg::OP_REMOVE, 32'h0000_0005, 1'b1, '{lase_pkg::STAT_NOT_FOUND, 5'd0, 1'b1}},
		'{lase_pkg::OP_ADD,    32'h8000_0000, 1'b1, '{lase_pkg::STAT_DONE, 5'd1, 1'b0}},
		'{lase_pkg::OP_ADD,    32'h7FFF_FFFF, 1'b1, '{lase_pkg::STAT_DONE, 5'd2, 1'b0}},
		'{lase_pkg::OP_ADD,    32'h8000_0000, 1'b1, '{lase_pkg::STAT_PRESENT, 5'd2, 1'b0}},
		'{lase_pkg::OP_SEARCH, 32'h7FFF_FFFF, 1'b1, '{lase_pkg::STAT_DONE, 5'd2, 1'b0}},
		'{lase_pkg::OP_ADD,    32'h0000_0000, 1'b0, '{lase_pkg::STAT_DONE, 5'd0, 1'b0}},
		'{lase_pkg::OP_ADD,    32'hFFFF_FFFF, 1'b0, '{lase_pkg::STAT_DONE, 5'd0, 1'b0}},
		'{lase_pkg::OP_ADD,    32'd1,         1'b0, '{lase_pkg::STAT_DONE, 5'd0, 1'b0}},
		'{lase_pkg::OP_ADD,    32'd2,         1'b0, '{lase_pkg::STAT_DONE, 5'd0, 1'b0}},
		'{lase_pkg::OP_ADD,    32'd3,         1'b0, '{lase_pkg::STAT_DONE, 5'd0, 1'b0}},
		'{lase_pkg::OP_ADD,    32'd4,         1'b0, '{lase_pkg::STAT_DONE, 5'd0, 1'b0}},
		'{lase_pkg::OP_ADD,    32'd5,         1'b0, '{lase_pkg::STAT_DONE, 5'd0, 1'b0}},
		'{lase_pkg::OP_ADD,    32'd6,         1'b0, '{lase_pkg::STAT_DONE, 5'd0, 1'b0}},
		'{lase_pkg::OP_ADD,    32'd7,         1'b0, '{lase_pkg::STAT_DONE, 5'd0, 1'b0}},
		'{lase_pkg::OP_ADD,    32'd8,         1'b0, '{lase_pkg::STAT_DONE, 5'd0, 1'b0}},
		'{lase_pkg::OP_ADD,    32'd9,         1'b0, '{lase_pkg::STAT_DONE, 5'd0, 1'b0}},
		'{lase_pkg::OP_ADD,    32'd10,        1'b0, '{lase_pkg::STAT_DONE, 5'd0, 1'b0}},
		'{lase_pkg::OP_ADD,    32'd11,        1'b0, '{lase_pkg::STAT_DONE, 5'd0, 1'b0}},
		'{lase_pkg::OP_ADD,    32'd12,        1'b0, '{lase_pkg::STAT_DONE, 5'd0, 1'b0}},
		// store is full now: a new value is rejected, a held one reports present
		'{lase_pkg::OP_ADD,    32'd99,        1'b1, '{lase_pkg::STAT_FULL, 5'd16, 1'b0}},
		'{lase_pkg::OP_ADD,    32'd5,         1'b1, '{lase_pkg::STAT_PRESENT, 5'd16, 1'b0}},
		// unlink head, tail and a middle slot, then reuse a freed slot
		'{lase_pkg::OP_REMOVE, 32'h8000_0000, 1'b1, '{lase_pkg::STAT_DONE, 5'd15, 1'b0}},
		'{lase_pkg::OP_REMOVE, 32'd12,        1'b0, '{lase_pkg::STAT_DONE, 5'd0, 1'b0}},
		'{lase_pkg::OP_REMOVE, 32'd5,         1'b0, '{lase_pkg::STAT_DONE, 5'd0, 1'b0}},
		'{lase_pkg::OP_ADD,    32'd77,        1'b0, '{lase_pkg::STAT_DONE, 5'd0, 1'b0}},
		'{lase_pkg::OP_CLEAR,  32'hA5A5_A5A5, 1'b1, '{lase_pkg::STAT_DONE, 5'd0, 1'b1}},
		'{lase_pkg::OP_SEARCH, 32'd77,        1'b1, '{lase_pkg::STAT_NOT_FOUND, 5'd0, 1'b1}}
	};

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        s_axis_tvalid = 1'b0;
	logic        s_axis_tready;
	logic [31:0] s_axis_tdata = '0;   // elem_value[31:0]
	logic [1:0]  s_axis_tuser = '0;   // op[1:0]
	logic        m_axis_tvalid;
	logic        m_axis_tready = 1'b0;
	logic [7:0]  m_axis_tdata;        // status[1:0], count[6:2], is_empty[7]

	linked_array_set_engine_unit uut (
		.clk           (clk),
		.arst_n        (arst_n),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.s_axis_tuser  (s_axis_tuser),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata)
	);

	initial begin
		forever #10 clk = ~clk;
	end

	// shadow copy of the set
	logic [lase_pkg::VALUE_W-1:0] chain_val  [lase_pkg::CAPACITY];
	logic [lase_pkg::LINK_W-1:0]  chain_link [lase_pkg::CAPACITY];
	logic [lase_pkg::LINK_W-1:0]  chain_head;
	logic [lase_pkg::LINK_W-1:0]  chain_tail;
	logic [lase_pkg::LINK_W-1:0]  free_top;
	logic [lase_pkg::COUNT_W-1:0] member_count;

	set_reply_t  pending_replies [$];
	int          mismatch_count = 0;
	int          beat_count = 0;
	int          cycle_count = 0;
	int          rx_wait = 0;
	bit          calm = 1'b0;
	logic [31:0] value_pool [POOL_SIZE];

	function automatic void rebuild_chain();
		for (int i = 0; i < lase_pkg::CAPACITY; i++) begin
			chain_link[i] = lase_pkg::LINK_W'(i + 1);
		end
		chain_head   = lase_pkg::NIL_LINK;
		chain_tail   = lase_pkg::NIL_LINK;
		free_top     = '0;
		member_count = '0;
	endfunction

	// walk from head; prev gets the slot before the hit
	function automatic logic [lase_pkg::LINK_W-1:0] locate(
			input logic [lase_pkg::VALUE_W-1:0] v,
			output logic [lase_pkg::LINK_W-1:0] prev);
		logic [lase_pkg::LINK_W-1:0] cur;
		logic [lase_pkg::LINK_W-1:0] trail;
		cur   = chain_head;
		trail = lase_pkg::NIL_LINK;
		prev  = lase_pkg::NIL_LINK;
		for (int steps = 0; steps < lase_pkg::CAPACITY && cur < lase_pkg::CAPACITY;
				steps++) begin
			if (chain_val[cur[lase_pkg::SLOT_W-1:0]] == v) begin
				prev = trail;
				return cur;
			end
			trail = cur;
			cur   = chain_link[cur[lase_pkg::SLOT_W-1:0]];
		end
		return lase_pkg::NIL_LINK;
	endfunction

	function automatic set_reply_t apply_set_op(input lase_pkg::op_t op,
			input logic [31:0] v);
		set_reply_t                  r;
		logic [lase_pkg::LINK_W-1:0] prev;
		logic [lase_pkg::LINK_W-1:0] slot;
		r.status = lase_pkg::STAT_DONE;
		case (op)
			lase_pkg::OP_ADD: begin
				if (member_count != 0 && locate(v, prev) != lase_pkg::NIL_LINK) begin
					r.status = lase_pkg::STAT_PRESENT;
				end else if (free_top >= lase_pkg::CAPACITY) begin
					r.status = lase_pkg::STAT_FULL;
				end else begin
					slot     = free_top;
					free_top = chain_link[slot[lase_pkg::SLOT_W-1:0]];
					chain_val[slot[lase_pkg::SLOT_W-1:0]]  = v;
					chain_link[slot[lase_pkg::SLOT_W-1:0]] = lase_pkg::NIL_LINK;
					if (chain_tail < lase_pkg::CAPACITY)
						chain_link[chain_tail[lase_pkg::SLOT_W-1:0]] = slot;
					else
						chain_head = slot;
					chain_tail   = slot;
					member_count = member_count + 1'b1;
				end
			end
			lase_pkg::OP_REMOVE: begin
				slot = (member_count == 0) ? lase_pkg::NIL_LINK : locate(v, prev);
				if (slot == lase_pkg::NIL_LINK) begin
					r.status = lase_pkg::STAT_NOT_FOUND;
				end else begin
					if (slot == chain_head)
						chain_head = chain_link[slot[lase_pkg::SLOT_W-1:0]];
					else if (prev < lase_pkg::CAPACITY)
						chain_link[prev[lase_pkg::SLOT_W-1:0]] =
							chain_link[slot[lase_pkg::SLOT_W-1:0]];
					if (slot == chain_tail) begin
						chain_tail = prev;
						if (prev < lase_pkg::CAPACITY)
							chain_link[prev[lase_pkg::SLOT_W-1:0]] = lase_pkg::NIL_LINK;
					end
					chain_link[slot[lase_pkg::SLOT_W-1:0]] = free_top;
					free_top     = slot;
					member_count = member_count - 1'b1;
				end
			end
			lase_pkg::OP_SEARCH: begin
				if (locate(v, prev) == lase_pkg::NIL_LINK)
					r.status = lase_pkg::STAT_NOT_FOUND;
			end
			default: begin
				rebuild_chain();
			end
		endcase
		r.count    = member_count;
		r.is_empty = (member_count == 0);
		return r;
	endfunction

	function automatic int draw_gap();
		return calm ? 0 : $urandom_range(0, 18);
	endfunction

	task automatic flag_mismatch(input string what, input int got, input int want);
		$display("mismatch at result beat %0d: %s got %0d want %0d",
			beat_count, what, got, want);
		mismatch_count++;
	endtask

	// hold the beat until accepted, log its reply, then idle for a drawn gap
	task automatic send_item(input lase_pkg::op_t op, input logic [31:0] v,
			input logic known, input set_reply_t known_reply);
		set_reply_t predicted;
		int         gap;
		s_axis_tvalid <= 1'b1;
		s_axis_tuser  <= op;
		s_axis_tdata  <= v;
		do @(posedge clk); while (!s_axis_tready);
		predicted = apply_set_op(op, v);
		pending_replies.push_back(known ? known_reply : predicted);
		gap = draw_gap();
		if (gap > 0) begin
			s_axis_tvalid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
	endtask

	// result side: check each beat, then stall for a drawn count
	always @(posedge clk) begin
		set_reply_t want;
		if (arst_n) begin
			if (m_axis_tvalid && m_axis_tready) begin
				beat_count++;
				if (pending_replies.size() == 0) begin
					flag_mismatch("unexpected beat, tdata", m_axis_tdata, 0);
				end else begin
					want = pending_replies.pop_front();
					if (m_axis_tdata[1:0] != want.status)
						flag_mismatch("status", m_axis_tdata[1:0], want.status);
					if (m_axis_tdata[6:2] != want.count)
						flag_mismatch("count", m_axis_tdata[6:2], want.count);
					if (m_axis_tdata[7] != want.is_empty)
						flag_mismatch("is_empty", m_axis_tdata[7], want.is_empty);
				end
				rx_wait = draw_gap();
			end else if (rx_wait > 0) begin
				rx_wait--;
			end
			m_axis_tready <= (rx_wait == 0);
		end
	end

	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("linked_array_set_engine_unit regression: fail");
			$finish;
		end
	end

	initial begin
		lase_pkg::op_t op;
		logic [31:0]   v;
		int            pick;
		int            add_share;

		for (int i = 0; i < lase_pkg::CAPACITY; i++) chain_val[i] = '0;
		rebuild_chain();
		value_pool[0] = 32'h0000_0000;
		value_pool[1] = 32'hFFFF_FFFF;
		value_pool[2] = 32'h8000_0000;
		value_pool[3] = 32'h7FFF_FFFF;
		for (int i = 4; i < POOL_SIZE; i++) value_pool[i] = $urandom;

		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		repeat (2) @(posedge clk);

		for (int r = 0; r < DIR_ROWS; r++) begin
			send_item(DIR_TABLE[r].op, DIR_TABLE[r].value, DIR_TABLE[r].known,
				DIR_TABLE[r].reply);
		end

		for (int i = 0; i < RANDOM_ITEMS; i++) begin
			calm = ((i / 100) % 4 == 3);
			if (i == RANDOM_ITEMS / 2) begin
				// drain the pipe completely before going on
				s_axis_tvalid <= 1'b0;
				while (pending_replies.size() != 0) @(posedge clk);
			end
			if (i % 50 == 49) value_pool[$urandom_range(4, POOL_SIZE - 1)] = $urandom;

			// alternate fill-heavy and balanced stretches
			add_share = ((i / 150) % 2 == 0) ? 65 : 40;
			pick = $urandom_range(0, 99);
			if (pick < add_share) op = lase_pkg::OP_ADD;
			else if (pick < add_share + (97 - add_share) / 2) op = lase_pkg::OP_REMOVE;
			else if (pick < 97) op = lase_pkg::OP_SEARCH;
			else op = lase_pkg::OP_CLEAR;

			if ($urandom_range(0, 9) < 8) v = value_pool[$urandom_range(0, POOL_SIZE - 1)];
			else v = $urandom;

			send_item(op, v, 1'b0, '0);
		end
		s_axis_tvalid <= 1'b0;
		calm = 1'b0;

		while (pending_replies.size() != 0) @(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);

		if (mismatch_count == 0) begin
			$display("linked_array_set_engine_unit regression: pass");
		end else begin
			$display("linked_array_set_engine_unit regression: fail");
		end
		$finish;
	end

endmodule

FILE: files.f
hw/rtl/lase_pkg.sv
hw/rtl/lase_ctrl.sv
hw/rtl/lase_dp.sv
hw/rtl/linked_array_set_engine_unit.sv
tb/linked_array_set_engine_unit_tb.sv
